[sv/lass_pkg.sv]
// Shared types, widths and constants of the LASS S-wave amplitude evaluator.
package lass_pkg;

    localparam int FRAC_BITS = 20;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 24;

    // Saturated intermediates stay below 2^(63-Q)
    localparam int SAT_W = 63 - FRAC_BITS;
    localparam logic [SAT_W-1:0] SAT_LIM = '1;
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    // Widths of input products after each Q shift
    localparam int MQ_W = 2 * IN_W - FRAC_BITS;
    localparam int T1_W = MQ_W + IN_W - FRAC_BITS;
    localparam int T2_W = T1_W + IN_W - FRAC_BITS;

    // Dividend widths of the front dividers
    localparam int D1_W  = T2_W + FRAC_BITS;
    localparam int D2_W  = SAT_W + FRAC_BITS;
    localparam int INV_W = 2 * FRAC_BITS + 1;
    localparam int D2SH  = SAT_W - FRAC_BITS;
    localparam int CMP_W = IN_W + D2SH;
    localparam int U_W   = 2 * FRAC_BITS + 2;

    // Normalised pair terms stay below 2^(NP+1)
    localparam int NP     = 30;
    localparam int NORM_W = NP + 1;
    localparam int IDX_W  = 6;
    localparam int PROD_W = 2 * NORM_W;
    localparam int DD_W   = PROD_W + 1 - FRAC_BITS;
    localparam int RAT_DW = PROD_W + 1;
    localparam int RAT_QW = FRAC_BITS + 2;
    localparam int MUL_W  = 2 * RAT_QW;
    localparam int SUM_W  = MUL_W + 1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BELOW  = 2'd1;
    localparam t_status ST_ABOVE  = 2'd2;
    localparam t_status ST_NO_REF = 2'd3;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RES_MASS  = 3'd0;
    localparam t_cfg_idx CFG_RES_WIDTH = 3'd1;
    localparam t_cfg_idx CFG_SCAT_LEN  = 3'd2;
    localparam t_cfg_idx CFG_EFF_RANGE = 3'd3;
    localparam t_cfg_idx CFG_WIN_LOW   = 3'd4;
    localparam t_cfg_idx CFG_WIN_HIGH  = 3'd5;

    typedef struct packed {
        logic [IN_W-1:0] pair_mass;
        logic [IN_W-1:0] breakup_momentum;
        logic [IN_W-1:0] reference_momentum;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] amp_real;
        logic signed [OUT_W-1:0] amp_imag;
        t_status                 status;
    } t_out_item;

    // Index of the leading one (zero for zero)
    function automatic logic [IDX_W-1:0] msb_idx(input logic [SAT_W-1:0] x);
        logic [IDX_W-1:0] p;
        p = '0;
        for (int i = 0; i < SAT_W; i++) begin
            if (x[i]) begin
                p = IDX_W'(i);
            end
        end
        return p;
    endfunction

endpackage

[sv/lass_s_wave_amplitude.sv]
// Top level: pipelined LASS K-pi S-wave amplitude evaluator.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One event enters per cycle while no result is held; each result passes through
// three rows of division cells in series (43, 43 and 22 cells).
// Reset is synchronous, clears the valid bits and reloads the configuration defaults.
// A held result freezes the whole pipeline, and then o_in_stall rises.
// Derived configuration products are ready for a transfer on the cycle after a write.
module lass_s_wave_amplitude (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lass_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lass_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  lass_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [lass_pkg::IN_W-1:0] i_cfg_data
);
    import lass_pkg::*;

    typedef struct packed {
        t_status  status;
        t_in_item item;
    } t_s1;

    typedef struct packed {
        t_status         status;
        logic [IN_W-1:0] m;
        logic [IN_W-1:0] q0;
        logic [T2_W-1:0] t2;
        logic [MQ_W-1:0] m2;
        logic [MQ_W-1:0] aq;
        logic [MQ_W-1:0] bq;
        logic            qnz;
    } t_s2;

    typedef struct packed {
        t_status           status;
        logic              sat1;
        logic [T2_W-1:0]   t2;
        logic [IN_W-1:0]   m;
        logic [IN_W-1:0]   q0;
        logic [MQ_W-1:0]   aq;
        logic [MQ_W-1:0]   r;
        logic              neg;
        logic              bg_en;
        logic [MQ_W-2:0]   bqh;
    } t_s3;

    typedef struct packed {
        t_status         status;
        logic            sat1;
        logic [IN_W-1:0] q0;
        logic [MQ_W-1:0] r;
        logic            neg;
        logic            bg_en;
        logic [MQ_W-2:0] bqh;
    } t_tag_a;

    typedef struct packed {
        t_status          status;
        logic             sat2;
        logic [SAT_W-1:0] c1;
        logic [IN_W-1:0]  q0;
        logic [MQ_W-1:0]  r;
        logic             neg;
        logic             bg_en;
        logic [U_W-1:0]   u;
    } t_s4;

    typedef struct packed {
        t_status         status;
        logic            sat2;
        logic [MQ_W-1:0] r;
        logic            neg;
        logic            bg_en;
        logic [U_W-1:0]  u;
    } t_tag_b;

    typedef struct packed {
        t_status            status;
        logic               czero;
        logic               neg;
        logic               bg_en;
        logic [NORM_W-1:0]  cn;
        logic [NORM_W-1:0]  rn;
        logic [NORM_W-1:0]  un;
        logic [FRAC_BITS:0] vn;
    } t_s5;

    typedef struct packed {
        t_status           status;
        logic              czero;
        logic              neg;
        logic              bg_en;
        logic [PROD_W-1:0] cc;
        logic [PROD_W-1:0] rr;
        logic [PROD_W-1:0] cr;
        logic [PROD_W-1:0] uu;
        logic [PROD_W-1:0] vv;
        logic [PROD_W-1:0] uv;
    } t_s6;

    typedef struct packed {
        t_status           status;
        logic              czero;
        logic              neg;
        logic              bg_en;
        logic              rneg;
        logic [DD_W-1:0]   ddb;
        logic [DD_W-1:0]   ddg;
        logic [RAT_DW-1:0] cr;
        logic [RAT_DW-1:0] cc;
        logic [RAT_DW-1:0] uv;
        logic [RAT_DW-1:0] vv;
        logic [RAT_DW-1:0] rmag;
        logic [RAT_DW-1:0] uv2;
    } t_s7;

    typedef struct packed {
        t_status status;
        logic    czero;
        logic    neg;
        logic    bg_en;
        logic    rneg;
    } t_tag_c;

    typedef struct packed {
        t_status                  status;
        logic signed [RAT_QW-1:0] bwr;
        logic signed [RAT_QW-1:0] bwi;
        logic signed [RAT_QW-1:0] bgr;
        logic signed [RAT_QW-1:0] bgi;
        logic signed [RAT_QW-1:0] rtr;
        logic signed [RAT_QW-1:0] rti;
    } t_s8;

    typedef struct packed {
        t_status                  status;
        logic signed [MUL_W-1:0]  prr;
        logic signed [MUL_W-1:0]  pii;
        logic signed [MUL_W-1:0]  pri;
        logic signed [MUL_W-1:0]  pir;
        logic signed [RAT_QW-1:0] bgr;
        logic signed [RAT_QW-1:0] bgi;
    } t_s9;

    function automatic logic signed [RAT_QW-1:0] clamp_one(input logic [RAT_QW-1:0] x);
        return (x > RAT_QW'(ONE_Q)) ? RAT_QW'(ONE_Q) : x;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] x);
        logic hi;
        logic lo;
        hi = &x[SUM_W-1:OUT_W-1];
        lo = |x[SUM_W-1:OUT_W-1];
        if (!x[SUM_W-1] && lo) begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end else if (x[SUM_W-1] && !hi) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end
        return x[OUT_W-1:0];
    endfunction

    // Configuration
    logic [IN_W-1:0] r_m0, r_g0, r_a, r_b, r_wlo, r_whi;
    logic [MQ_W-1:0] r_m02;
    logic [T1_W-1:0] r_t1;
    logic [IN_W-1:0]        w_m0_nxt;
    logic [2*IN_W-1:0]      w_m0sq;
    logic [MQ_W+IN_W-1:0]   w_t1f;

    // Pipeline
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v_out;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;
    t_s7 r_s7, n_s7;
    t_s8 r_s8, n_s8;
    t_s9 r_s9, n_s9;
    t_out_item r_out, n_out;

    logic [T1_W+IN_W-1:0] w_t2f;
    logic [2*IN_W-1:0]    w_m2f, w_aqf, w_bqf;

    t_tag_a            w_tag_a_in, w_tag_a_out;
    logic              w_va;
    logic [SAT_W-1:0]  w_qa1, w_qa2;

    t_tag_b            w_tag_b_in, w_tag_b_out;
    logic              w_vb;
    logic [SAT_W-1:0]  w_qb;

    logic [SAT_W-1:0]      w_c, w_rx, w_mx;
    logic [IDX_W-1:0]      w_pc, w_pu, w_su;
    logic [SAT_W+NP-1:0]   w_cs, w_rs;

    logic [PROD_W:0]       w_sumb, w_sumg;

    t_tag_c            w_tag_c_in, w_tag_c_out;
    logic              w_vc;
    logic [RAT_QW-1:0] w_q_bwr, w_q_bwi, w_q_bgr, w_q_bgi, w_q_rtr, w_q_rti;

    logic signed [SUM_W-1:0] w_dre, w_dim, w_re, w_im;

    assign w_en       = !r_v_out || !i_out_stall;
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0  <= IN_W'(1506804);
            r_g0  <= IN_W'(372244);
            r_a   <= IN_W'(2023752);
            r_b   <= IN_W'(2789212);
            r_wlo <= IN_W'(663972);
            r_whi <= IN_W'(1782579);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RES_MASS:  r_m0  <= i_cfg_data;
                CFG_RES_WIDTH: r_g0  <= i_cfg_data;
                CFG_SCAT_LEN:  r_a   <= i_cfg_data;
                CFG_EFF_RANGE: r_b   <= i_cfg_data;
                CFG_WIN_LOW:   r_wlo <= i_cfg_data;
                CFG_WIN_HIGH:  r_whi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // m0^2 tracks the value r_m0 takes at this edge; m0^2*g0 is registered from r_m02 and r_g0
    assign w_m0_nxt = !i_rst_n ? IN_W'(1506804) :
                      (i_cfg_we && (i_cfg_idx == CFG_RES_MASS)) ? i_cfg_data : r_m0;
    assign w_m0sq = w_m0_nxt * w_m0_nxt;
    assign w_t1f  = r_m02 * r_g0;

    always_ff @(posedge i_clk) begin
        r_m02 <= w_m0sq[2*IN_W-1:FRAC_BITS];
        r_t1  <= w_t1f[MQ_W+IN_W-1:FRAC_BITS];
    end

    // Stage 1: window and reference checks
    always_comb begin
        n_s1.item = i_in_data;
        if (i_in_data.pair_mass <= r_wlo) begin
            n_s1.status = ST_BELOW;
        end else if (i_in_data.pair_mass >= r_whi) begin
            n_s1.status = ST_ABOVE;
        end else if (i_in_data.reference_momentum == '0) begin
            n_s1.status = ST_NO_REF;
        end else begin
            n_s1.status = ST_OK;
        end
    end

    // Stage 2: products against the input
    assign w_t2f = r_t1 * r_s1.item.breakup_momentum;
    assign w_m2f = r_s1.item.pair_mass * r_s1.item.pair_mass;
    assign w_aqf = r_a * r_s1.item.breakup_momentum;
    assign w_bqf = r_b * r_s1.item.breakup_momentum;

    always_comb begin
        n_s2.status = r_s1.status;
        n_s2.m      = r_s1.item.pair_mass;
        n_s2.q0     = r_s1.item.reference_momentum;
        n_s2.t2     = w_t2f[T1_W+IN_W-1:FRAC_BITS];
        n_s2.m2     = w_m2f[2*IN_W-1:FRAC_BITS];
        n_s2.aq     = w_aqf[2*IN_W-1:FRAC_BITS];
        n_s2.bq     = w_bqf[2*IN_W-1:FRAC_BITS];
        n_s2.qnz    = r_s1.item.breakup_momentum != '0;
    end

    // Stage 3: overflow of the first quotient, mass distance, background enable
    always_comb begin
        n_s3.status = r_s2.status;
        n_s3.sat1   = CMP_W'(r_s2.t2) >= {r_s2.m, {D2SH{1'b0}}};
        n_s3.t2     = r_s2.t2;
        n_s3.m      = r_s2.m;
        n_s3.q0     = r_s2.q0;
        n_s3.aq     = r_s2.aq;
        n_s3.neg    = r_s2.m2 > r_m02;
        n_s3.r      = n_s3.neg ? r_s2.m2 - r_m02 : r_m02 - r_s2.m2;
        n_s3.bg_en  = r_s2.qnz && (r_s2.aq != '0);
        n_s3.bqh    = r_s2.bq[MQ_W-1:1];
    end

    always_comb begin
        w_tag_a_in.status = r_s3.status;
        w_tag_a_in.sat1   = r_s3.sat1;
        w_tag_a_in.q0     = r_s3.q0;
        w_tag_a_in.r      = r_s3.r;
        w_tag_a_in.neg    = r_s3.neg;
        w_tag_a_in.bg_en  = r_s3.bg_en;
        w_tag_a_in.bqh    = r_s3.bqh;
    end

    // m0^2*g0*q / m
    lass_div_row #(
        .DW(D1_W), .SW(IN_W), .QW(SAT_W), .TW($bits(t_tag_a))
    ) u_div_c1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v3),
        .i_dividend({r_s3.t2, {FRAC_BITS{1'b0}}}), .i_divisor(r_s3.m),
        .i_tag(w_tag_a_in), .o_vld(w_va), .o_quot(w_qa1), .o_tag(w_tag_a_out)
    );

    // 1 / (a*q)
    lass_div_row #(
        .DW(INV_W), .SW(MQ_W), .QW(SAT_W), .TW(1)
    ) u_div_inv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v3),
        .i_dividend({1'b1, {(INV_W-1){1'b0}}}), .i_divisor(r_s3.aq),
        .i_tag(1'b0), .o_vld(), .o_quot(w_qa2), .o_tag()
    );

    // Stage 4: saturate, cotangent sum
    always_comb begin
        n_s4.status = w_tag_a_out.status;
        n_s4.c1     = w_tag_a_out.sat1 ? SAT_LIM : w_qa1;
        n_s4.sat2   = CMP_W'(n_s4.c1) >= {w_tag_a_out.q0, {D2SH{1'b0}}};
        n_s4.q0     = w_tag_a_out.q0;
        n_s4.r      = w_tag_a_out.r;
        n_s4.neg    = w_tag_a_out.neg;
        n_s4.bg_en  = w_tag_a_out.bg_en;
        n_s4.u      = U_W'(w_qa2) + U_W'(w_tag_a_out.bqh);
    end

    always_comb begin
        w_tag_b_in.status = r_s4.status;
        w_tag_b_in.sat2   = r_s4.sat2;
        w_tag_b_in.r      = r_s4.r;
        w_tag_b_in.neg    = r_s4.neg;
        w_tag_b_in.bg_en  = r_s4.bg_en;
        w_tag_b_in.u      = r_s4.u;
    end

    // ... / q0
    lass_div_row #(
        .DW(D2_W), .SW(IN_W), .QW(SAT_W), .TW($bits(t_tag_b))
    ) u_div_c2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v4),
        .i_dividend({r_s4.c1, {FRAC_BITS{1'b0}}}), .i_divisor(r_s4.q0),
        .i_tag(w_tag_b_in), .o_vld(w_vb), .o_quot(w_qb), .o_tag(w_tag_b_out)
    );

    // Stage 5: bring both pairs into the normalised range
    assign w_c   = w_tag_b_out.sat2 ? SAT_LIM : w_qb;
    assign w_rx  = SAT_W'(w_tag_b_out.r);
    assign w_mx  = (w_c > w_rx) ? w_c : w_rx;
    assign w_pc  = msb_idx(w_mx);
    assign w_cs  = {w_c, {NP{1'b0}}} >> w_pc;
    assign w_rs  = {w_rx, {NP{1'b0}}} >> w_pc;
    assign w_pu  = msb_idx(SAT_W'(w_tag_b_out.u));
    assign w_su  = (w_pu > IDX_W'(NP)) ? w_pu - IDX_W'(NP) : '0;

    always_comb begin
        n_s5.status = w_tag_b_out.status;
        n_s5.czero  = w_c == '0;
        n_s5.neg    = w_tag_b_out.neg;
        n_s5.bg_en  = w_tag_b_out.bg_en;
        n_s5.cn     = w_cs[NORM_W-1:0];
        n_s5.rn     = w_rs[NORM_W-1:0];
        n_s5.un     = NORM_W'(w_tag_b_out.u >> w_su);
        n_s5.vn     = ONE_Q >> w_su;
    end

    // Stage 6: squares and cross products
    always_comb begin
        n_s6.status = r_s5.status;
        n_s6.czero  = r_s5.czero;
        n_s6.neg    = r_s5.neg;
        n_s6.bg_en  = r_s5.bg_en;
        n_s6.cc     = r_s5.cn * r_s5.cn;
        n_s6.rr     = r_s5.rn * r_s5.rn;
        n_s6.cr     = r_s5.cn * r_s5.rn;
        n_s6.uu     = r_s5.un * r_s5.un;
        n_s6.vv     = r_s5.vn * r_s5.vn;
        n_s6.uv     = r_s5.un * r_s5.vn;
    end

    // Stage 7: denominators and signed rotation numerator
    assign w_sumb = {1'b0, r_s6.cc} + {1'b0, r_s6.rr};
    assign w_sumg = {1'b0, r_s6.uu} + {1'b0, r_s6.vv};

    always_comb begin
        n_s7.status = r_s6.status;
        n_s7.czero  = r_s6.czero;
        n_s7.neg    = r_s6.neg;
        n_s7.bg_en  = r_s6.bg_en;
        n_s7.rneg   = r_s6.uu < r_s6.vv;
        n_s7.ddb    = w_sumb[PROD_W:FRAC_BITS];
        n_s7.ddg    = w_sumg[PROD_W:FRAC_BITS];
        n_s7.cr     = RAT_DW'(r_s6.cr);
        n_s7.cc     = RAT_DW'(r_s6.cc);
        n_s7.uv     = RAT_DW'(r_s6.uv);
        n_s7.vv     = RAT_DW'(r_s6.vv);
        n_s7.rmag   = n_s7.rneg ? RAT_DW'(r_s6.vv - r_s6.uu) : RAT_DW'(r_s6.uu - r_s6.vv);
        n_s7.uv2    = {r_s6.uv, 1'b0};
    end

    always_comb begin
        w_tag_c_in.status = r_s7.status;
        w_tag_c_in.czero  = r_s7.czero;
        w_tag_c_in.neg    = r_s7.neg;
        w_tag_c_in.bg_en  = r_s7.bg_en;
        w_tag_c_in.rneg   = r_s7.rneg;
    end

    lass_div_row #(
        .DW(RAT_DW), .SW(DD_W), .QW(RAT_QW), .TW($bits(t_tag_c))
    ) u_div_bwr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v7),
        .i_dividend(r_s7.cr), .i_divisor(r_s7.ddb),
        .i_tag(w_tag_c_in), .o_vld(w_vc), .o_quot(w_q_bwr), .o_tag(w_tag_c_out)
    );

    lass_div_row #(
        .DW(RAT_DW), .SW(DD_W), .QW(RAT_QW), .TW(1)
    ) u_div_bwi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v7),
        .i_dividend(r_s7.cc), .i_divisor(r_s7.ddb),
        .i_tag(1'b0), .o_vld(), .o_quot(w_q_bwi), .o_tag()
    );

    lass_div_row #(
        .DW(RAT_DW), .SW(DD_W), .QW(RAT_QW), .TW(1)
    ) u_div_bgr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v7),
        .i_dividend(r_s7.uv), .i_divisor(r_s7.ddg),
        .i_tag(1'b0), .o_vld(), .o_quot(w_q_bgr), .o_tag()
    );

    lass_div_row #(
        .DW(RAT_DW), .SW(DD_W), .QW(RAT_QW), .TW(1)
    ) u_div_bgi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v7),
        .i_dividend(r_s7.vv), .i_divisor(r_s7.ddg),
        .i_tag(1'b0), .o_vld(), .o_quot(w_q_bgi), .o_tag()
    );

    lass_div_row #(
        .DW(RAT_DW), .SW(DD_W), .QW(RAT_QW), .TW(1)
    ) u_div_rtr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v7),
        .i_dividend(r_s7.rmag), .i_divisor(r_s7.ddg),
        .i_tag(1'b0), .o_vld(), .o_quot(w_q_rtr), .o_tag()
    );

    lass_div_row #(
        .DW(RAT_DW), .SW(DD_W), .QW(RAT_QW), .TW(1)
    ) u_div_rti (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_v7),
        .i_dividend(r_s7.uv2), .i_divisor(r_s7.ddg),
        .i_tag(1'b0), .o_vld(), .o_quot(w_q_rti), .o_tag()
    );

    // Stage 8: clamp, sign, drop terms that vanish
    always_comb begin
        n_s8.status = w_tag_c_out.status;
        if (w_tag_c_out.czero) begin
            n_s8.bwr = '0;
            n_s8.bwi = '0;
        end else begin
            n_s8.bwr = w_tag_c_out.neg ? -clamp_one(w_q_bwr) : clamp_one(w_q_bwr);
            n_s8.bwi = clamp_one(w_q_bwi);
        end
        if (w_tag_c_out.bg_en) begin
            n_s8.bgr = clamp_one(w_q_bgr);
            n_s8.bgi = clamp_one(w_q_bgi);
            n_s8.rtr = w_tag_c_out.rneg ? -clamp_one(w_q_rtr) : clamp_one(w_q_rtr);
            n_s8.rti = clamp_one(w_q_rti);
        end else begin
            n_s8.bgr = '0;
            n_s8.bgi = '0;
            n_s8.rtr = RAT_QW'(ONE_Q);
            n_s8.rti = '0;
        end
    end

    // Stage 9: complex rotation products
    always_comb begin
        n_s9.status = r_s8.status;
        n_s9.prr    = r_s8.bwr * r_s8.rtr;
        n_s9.pii    = r_s8.bwi * r_s8.rti;
        n_s9.pri    = r_s8.bwr * r_s8.rti;
        n_s9.pir    = r_s8.bwi * r_s8.rtr;
        n_s9.bgr    = r_s8.bgr;
        n_s9.bgi    = r_s8.bgi;
    end

    // Output stage: floor to Q, add background, saturate; zero on a non-ok status
    assign w_dre = SUM_W'(r_s9.prr) - SUM_W'(r_s9.pii);
    assign w_dim = SUM_W'(r_s9.pri) + SUM_W'(r_s9.pir);
    assign w_re  = (w_dre >>> FRAC_BITS) + SUM_W'(r_s9.bgr);
    assign w_im  = (w_dim >>> FRAC_BITS) + SUM_W'(r_s9.bgi);

    always_comb begin
        n_out.status = r_s9.status;
        if (r_s9.status != ST_OK) begin
            n_out.amp_real = '0;
            n_out.amp_imag = '0;
        end else begin
            n_out.amp_real = sat_out(w_re);
            n_out.amp_imag = sat_out(w_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            r_v7    <= 1'b0;
            r_v8    <= 1'b0;
            r_v9    <= 1'b0;
            r_v_out <= 1'b0;
        end else if (w_en) begin
            r_v1    <= i_in_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= w_va;
            r_v5    <= w_vb;
            r_v6    <= r_v5;
            r_v7    <= r_v6;
            r_v8    <= w_vc;
            r_v9    <= r_v8;
            r_v_out <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_s6  <= n_s6;
            r_s7  <= n_s7;
            r_s8  <= n_s8;
            r_s9  <= n_s9;
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v_out;
    assign o_out_data  = r_out;

endmodule

[sv/lass_div_cell.sv]
// One restoring division step: trial subtract of the shifted divisor, one quotient bit.
module lass_div_cell #(
    parameter int DW   = 8,
    parameter int SW   = 8,
    parameter int QW   = 8,
    parameter int TW   = 1,
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem,
    input  logic [SW-1:0] i_dvs,
    input  logic [QW-1:0] i_quot,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_dvs,
    output logic [QW-1:0] o_quot,
    output logic [TW-1:0] o_tag
);
    localparam int CW = (DW > SW + QW) ? DW : SW + QW;

    logic [CW-1:0] w_trial;
    logic [CW-1:0] w_rem;
    logic          w_take;
    logic          r_vld;
    logic [DW-1:0] r_rem;
    logic [SW-1:0] r_dvs;
    logic [QW-1:0] r_quot;
    logic [TW-1:0] r_tag;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_quot;

    assign w_trial = CW'(i_dvs) << STEP;
    assign w_rem   = CW'(i_rem);
    assign w_take  = w_rem >= w_trial;
    assign n_rem   = w_take ? DW'(w_rem - w_trial) : i_rem;
    assign n_quot  = i_quot | (QW'(w_take) << STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_dvs  <= i_dvs;
            r_quot <= n_quot;
            r_tag  <= i_tag;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_dvs  = r_dvs;
    assign o_quot = r_quot;
    assign o_tag  = r_tag;

endmodule

[sv/lass_div_row.sv]
// Row of division cells, one quotient bit per cell, with a side tag riding along.
module lass_div_row #(
    parameter int DW = 8,
    parameter int SW = 8,
    parameter int QW = 8,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QW-1:0] o_quot,
    output logic [TW-1:0] o_tag
);
    logic          w_vld  [0:QW];
    logic [DW-1:0] w_rem  [0:QW];
    logic [SW-1:0] w_dvs  [0:QW];
    logic [QW-1:0] w_quot [0:QW];
    logic [TW-1:0] w_tag  [0:QW];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = i_dividend;
    assign w_dvs[0]  = i_divisor;
    assign w_quot[0] = '0;
    assign w_tag[0]  = i_tag;

    // Most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_cell
        lass_div_cell #(
            .DW(DW), .SW(SW), .QW(QW), .TW(TW), .STEP(QW - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_vld  (w_vld[k]),
            .i_rem  (w_rem[k]),
            .i_dvs  (w_dvs[k]),
            .i_quot (w_quot[k]),
            .i_tag  (w_tag[k]),
            .o_vld  (w_vld[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_dvs  (w_dvs[k+1]),
            .o_quot (w_quot[k+1]),
            .o_tag  (w_tag[k+1])
        );
    end

    assign o_vld  = w_vld[QW];
    assign o_quot = w_quot[QW];
    assign o_tag  = w_tag[QW];

endmodule

[sv/lass_chk.sv]
// Port-level checks of the amplitude evaluator, bound to the top level.
module lass_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lass_pkg::t_out_item o_out_data
);
    import lass_pkg::*;

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("held result changed");

    // Any non-ok status carries a zero amplitude
    a_zero_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
            (o_out_data.amp_real == '0) && (o_out_data.amp_imag == '0))
        else $error("non-zero amplitude with error status");

    // Input is held back only by a stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind lass_s_wave_amplitude lass_chk u_lass_chk (.*);

[tb/lass_amp_checker.sv]
// Checker for the LASS S-wave evaluator: watches the channels, predicts amplitudes, compares.
`timescale 1ns / 100ps

module lass_amp_checker
    import lass_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_in_item            i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_out_item           i_out_data,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [IN_W-1:0]     i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    localparam longint unsigned U_ONE  = 64'd1 << FRAC_BITS;
    localparam longint unsigned U_SAT  = (64'd1 << (63 - FRAC_BITS)) - 64'd1;
    localparam longint unsigned U_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam longint unsigned U_HI31 = 64'd1 << 31;
    localparam longint unsigned U_HI30 = 64'd1 << 30;

    longint unsigned res_mass, res_width, scat_len, eff_range, win_low, win_high;
    t_out_item       amp_queue[$];
    int              errors;

    assign o_errors  = errors;
    assign o_pending = amp_queue.size();

    function automatic longint unsigned q_mul(longint unsigned x, longint unsigned y);
        longint unsigned p;
        if (y != 0 && x > U_MAX / y) return U_SAT;
        p = (x * y) >> FRAC_BITS;
        return (p > U_SAT) ? U_SAT : p;
    endfunction

    function automatic longint unsigned q_div(longint unsigned x, longint unsigned y);
        longint unsigned r;
        if (y == 0) return U_SAT;
        if (x > U_SAT) x = U_SAT;
        r = (x << FRAC_BITS) / y;
        return (r > U_SAT) ? U_SAT : r;
    endfunction

    function automatic longint unsigned unit_clamp(longint unsigned x);
        return (x > U_ONE) ? U_ONE : x;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(longint v);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_out_item predict_amplitude(t_in_item ev);
        t_out_item       res;
        longint unsigned m, q, q0, c, r, m2, m02, mx, d, dd, aq, u, v;
        longint          bw_re, bw_im, bg_re, bg_im, rot_re, rot_im, re, im;
        logic            neg;
        m  = ev.pair_mass;
        q  = ev.breakup_momentum;
        q0 = ev.reference_momentum;
        res = '0;
        if (m <= win_low) res.status = ST_BELOW;
        else if (m >= win_high) res.status = ST_ABOVE;
        else if (q0 == 0) res.status = ST_NO_REF;
        if (res.status != ST_OK) return res;
        bw_re = 0; bw_im = 0; bg_re = 0; bg_im = 0;
        rot_re = longint'(U_ONE); rot_im = 0;
        // Breit-Wigner term
        c = q_mul(q_mul(q_mul(res_mass, res_mass), res_width), q);
        c = q_div(q_div(c, m), q0);
        m2  = q_mul(m, m);
        m02 = q_mul(res_mass, res_mass);
        neg = m2 > m02;
        r = neg ? m2 - m02 : m02 - m2;
        if (c != 0) begin
            mx = (c > r) ? c : r;
            while (mx >= U_HI31) begin c >>= 1; r >>= 1; mx >>= 1; end
            while (mx < U_HI30) begin c <<= 1; r <<= 1; mx <<= 1; end
            d  = c * c + r * r;
            dd = d >> FRAC_BITS;
            bw_re = longint'(unit_clamp((c * r) / dd));
            if (neg) bw_re = -bw_re;
            bw_im = longint'(unit_clamp((c * c) / dd));
        end
        // Background phase from the cotangent
        aq = q_mul(scat_len, q);
        if (q != 0 && aq != 0) begin
            u = q_div(U_ONE, aq) + (q_mul(eff_range, q) >> 1);
            v = U_ONE;
            if (u > U_SAT) u = U_SAT;
            while (u >= U_HI31) begin u >>= 1; v >>= 1; end
            dd = (u * u + v * v) >> FRAC_BITS;
            bg_re = longint'(unit_clamp((u * v) / dd));
            bg_im = longint'(unit_clamp((v * v) / dd));
            rot_re = (longint'(u * u) - longint'(v * v)) / longint'(dd);
            if (rot_re > longint'(U_ONE)) rot_re = longint'(U_ONE);
            if (rot_re < -longint'(U_ONE)) rot_re = -longint'(U_ONE);
            rot_im = longint'(unit_clamp((2 * u * v) / dd));
        end
        re = bg_re + ((bw_re * rot_re - bw_im * rot_im) >>> FRAC_BITS);
        im = bg_im + ((bw_re * rot_im + bw_im * rot_re) >>> FRAC_BITS);
        res.amp_real = sat_out(re);
        res.amp_imag = sat_out(im);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            res_mass  = 1506804;
            res_width = 372244;
            scat_len  = 2023752;
            eff_range = 2789212;
            win_low   = 663972;
            win_high  = 1782579;
            amp_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RES_MASS:  res_mass  = i_cfg_data;
                    CFG_RES_WIDTH: res_width = i_cfg_data;
                    CFG_SCAT_LEN:  scat_len  = i_cfg_data;
                    CFG_EFF_RANGE: eff_range = i_cfg_data;
                    CFG_WIN_LOW:   win_low   = i_cfg_data;
                    CFG_WIN_HIGH:  win_high  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) amp_queue.push_back(predict_amplitude(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (amp_queue.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $realtime);
                    errors++;
                end else begin
                    want = amp_queue.pop_front();
                    if (i_out_data.amp_real !== want.amp_real)
                        report_mismatch("amp_real", i_out_data.amp_real, want.amp_real);
                    if (i_out_data.amp_imag !== want.amp_imag)
                        report_mismatch("amp_imag", i_out_data.amp_imag, want.amp_imag);
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", i_out_data.status, want.status);
                end
            end
        end
    end

    final begin
    end

endmodule

[tb/tb.sv]
// Testbench top: stimulus, configuration phases and verdict for the LASS S-wave evaluator.
`timescale 1ns / 100ps

module tb;
    import lass_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 130;
    localparam logic [IN_W-1:0] FULL = '1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [IN_W-1:0] i_cfg_data;
    int          mismatches;
    int          pending;
    int          cycles;
    logic        hold_req;
    logic [IN_W-1:0] win_lo, win_hi;

    lass_s_wave_amplitude i_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
        .o_out_valid, .i_out_stall, .o_out_data, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    lass_amp_checker i_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_data(o_out_data),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(mismatches), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(50, 200)) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    task automatic send_event(logic [IN_W-1:0] m, logic [IN_W-1:0] q, logic [IN_W-1:0] q0,
                              bit with_gaps);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= '{pair_mass: m, breakup_momentum: q, reference_momentum: q0};
        do @(posedge i_clk); while (o_in_stall);
        gap = with_gaps ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain the pipe, then write all six registers back to back
    task automatic load_config(logic [IN_W-1:0] m0, logic [IN_W-1:0] g0,
                               logic [IN_W-1:0] a, logic [IN_W-1:0] b,
                               logic [IN_W-1:0] lo, logic [IN_W-1:0] hi);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_RES_MASS;  i_cfg_data <= m0; @(posedge i_clk);
        i_cfg_idx <= CFG_RES_WIDTH; i_cfg_data <= g0; @(posedge i_clk);
        i_cfg_idx <= CFG_SCAT_LEN;  i_cfg_data <= a;  @(posedge i_clk);
        i_cfg_idx <= CFG_EFF_RANGE; i_cfg_data <= b;  @(posedge i_clk);
        i_cfg_idx <= CFG_WIN_LOW;   i_cfg_data <= lo; @(posedge i_clk);
        i_cfg_idx <= CFG_WIN_HIGH;  i_cfg_data <= hi; @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (4) @(posedge i_clk);
        win_lo = lo;
        win_hi = hi;
    endtask

    task automatic send_random(int count);
        logic [IN_W-1:0] m, q, q0;
        int p;
        repeat (count) begin
            p = $urandom_range(0, 99);
            if (p < 80 && win_hi > win_lo + 24'd1)
                m = IN_W'($urandom_range(win_lo + 24'd1, win_hi - 24'd1));
            else if (p < 90) begin
                case ($urandom_range(0, 3))
                    0: m = win_lo;
                    1: m = win_lo + 24'd1;
                    2: m = win_hi - 24'd1;
                    default: m = win_hi;
                endcase
            end else m = IN_W'($urandom_range(0, FULL));
            p = $urandom_range(0, 99);
            if (p < 35) q = IN_W'($urandom_range(0, FULL));
            else if (p < 80) q = IN_W'($urandom_range(0, 1 << 21));
            else if (p < 90) q = '0;
            else q = IN_W'($urandom_range(1, 15));
            p = $urandom_range(0, 99);
            if (p < 5) q0 = '0;
            else if (p < 50) q0 = IN_W'($urandom_range(0, FULL));
            else q0 = IN_W'($urandom_range(1, 1 << 21));
            send_event(m, q, q0, 1'b1);
        end
    endtask

    initial begin
        logic [IN_W-1:0] r0, r1;
        cycles     = 0;
        hold_req   = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_RES_MASS;
        i_cfg_data = '0;
        win_lo     = 24'd663972;
        win_hi     = 24'd1782579;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events at the reset configuration
        send_event('0, 24'd500000, 24'd400000, 1'b0);           // zero mass
        send_event(win_lo, 24'd500000, 24'd400000, 1'b0);      // on the low edge
        send_event(win_lo + 24'd1, 24'd500000, 24'd400000, 1'b1);
        send_event(win_hi - 24'd1, 24'd500000, 24'd400000, 1'b0);
        send_event(win_hi, 24'd500000, 24'd400000, 1'b0);      // on the high edge
        send_event(FULL, FULL, FULL, 1'b1);
        send_event(24'd1506804, 24'd500000, '0, 1'b0);          // no reference momentum
        send_event(24'd1506804, '0, 24'd400000, 1'b0);          // zero background
        send_event(24'd1506804, 24'd400000, 24'd400000, 1'b0);  // on resonance
        send_event(24'd1000000, FULL, 24'd1, 1'b1);             // saturating width term
        send_event(24'd1000000, 24'd1, FULL, 1'b0);             // width term vanishes
        send_event(24'd1000000, 24'd1, 24'd1, 1'b0);            // a*q truncates to a single LSB
        send_event(24'd1700000, FULL, FULL, 1'b0);
        send_event(24'd700000, 24'd12345, 24'd54321, 1'b1);
        send_event(24'd1200000, 24'h555555, 24'hAAAAAA, 1'b0);
        send_event(24'd1300000, 24'hAAAAAA, 24'h555555, 1'b0);
        send_random(200);

        // Receiver holds off while the sender keeps offering
        hold_req <= 1'b1;
        send_random(250);

        // All registers at zero: every event falls outside the window
        load_config('0, '0, '0, '0, '0, '0);
        send_random(60);
        // All model registers at full scale, with the widest window
        load_config(FULL, FULL, FULL, FULL, '0, FULL);
        send_random(200);
        // Empty window: low at the high limit
        load_config(24'd1506804, 24'd372244, 24'd2023752, 24'd2789212,
                    24'd1200000, 24'd1200000);
        send_random(60);
        // No background: zero scattering length
        load_config(24'd1506804, 24'd372244, '0, 24'd2789212, 24'd600000, 24'd2000000);
        send_random(150);
        repeat (5) begin
            r0 = IN_W'($urandom_range(0, 1 << 21));
            r1 = IN_W'($urandom_range(0, FULL));
            load_config(IN_W'($urandom_range(0, FULL)), IN_W'($urandom_range(0, 1 << 21)),
                        IN_W'($urandom_range(0, FULL)), IN_W'($urandom_range(0, FULL)),
                        (r0 < r1) ? r0 : r1, (r0 < r1) ? r1 : r0);
            send_random(120);
        end
        load_config(24'd1506804, 24'd372244, 24'd2023752, 24'd2789212, 24'd663972, 24'd1782579);
        send_random(160);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
